[sv/nhrw_pkg.sv]
// ----------------------------------------------------------------------------
// nhrw_pkg
// Shared types and constants for the IPv4 next-hop rewrite engine.
// ----------------------------------------------------------------------------
package nhrw_pkg;

    localparam logic [15:0] CKSUM_ADJ = 16'h0100;
    localparam logic [15:0] EDGE_NONE = 16'h0000;

    typedef enum logic [1:0] {
        FN_PACKET   = 2'd0,
        FN_SET_EDGE = 2'd1,
        FN_STAGE    = 2'd2,
        FN_COMMIT   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HOP = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_NO_EDGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECIDE,
        S_EMIT,
        S_COPY,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic clr;
        logic fetch;
        logic decide;
        logic emit;
        logic copy;
        logic resp;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  go_long;
        logic  cnt_last;
        logic  clr_last;
    } t_dp_stat;

endpackage

[sv/nhrw_ctrl.sv]
// ----------------------------------------------------------------------------
// nhrw_ctrl
// Request sequencer: table clear after reset, lookup, byte emission and
// commit copy, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module nhrw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  nhrw_pkg::t_dp_stat i_stat,
    output nhrw_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import nhrw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_stat.go_long) begin
                    n_state = S_RESP;
                end else if (i_stat.func == FN_PACKET) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_COPY;
                end
            end
            S_EMIT: begin
                if (i_stat.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_COPY: begin
                if (i_stat.cnt_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_FETCH:  o_cmd.fetch  = 1'b1;
            S_DECIDE: o_cmd.decide = 1'b1;
            S_EMIT:   o_cmd.emit   = 1'b1;
            S_COPY:   o_cmd.copy   = 1'b1;
            S_RESP:   o_cmd.resp   = 1'b1;
            default:  o_busy       = 1'b1;
        endcase
    end

endmodule

[sv/nhrw_dp.sv]
// ----------------------------------------------------------------------------
// nhrw_dp
// Datapath: port edge table, next-hop entry table, rewrite byte store,
// staging buffer, checksum and TTL update, result registers.
// ----------------------------------------------------------------------------
module nhrw_dp #(
    parameter int NUM_HOPS    = 64,
    parameter int MAX_REWRITE = 56,
    parameter int NUM_PORTS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nhrw_pkg::t_dp_cmd  i_cmd,
    output nhrw_pkg::t_dp_stat o_stat,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_hop_id,
    input  logic [7:0]         i_ttl,
    input  logic [15:0]        i_cksum,
    input  logic [4:0]         i_port,
    input  logic [15:0]        i_edge_req,
    input  logic [5:0]         i_byte_index,
    input  logic [7:0]         i_byte_value,
    input  logic [7:0]         i_length,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [15:0]        o_out_edge,
    output logic [7:0]         o_new_ttl,
    output logic [15:0]        o_new_cksum,
    output logic [7:0]         o_hdr_byte,
    output logic [5:0]         o_hdr_index,
    output logic               o_hdr_valid,
    output logic               o_last
);
    import nhrw_pkg::*;

    localparam int HW = (NUM_HOPS > 1) ? $clog2(NUM_HOPS) : 1;
    localparam int LW = $clog2(MAX_REWRITE + 1);
    localparam int KW = (MAX_REWRITE > 1) ? $clog2(MAX_REWRITE) : 1;
    localparam int PD = (NUM_PORTS < 32) ? NUM_PORTS : 32;
    localparam int PW = (PD > 1) ? $clog2(PD) : 1;
    localparam int SD = NUM_HOPS * MAX_REWRITE;
    localparam int SW = (SD > 1) ? $clog2(SD) : 1;
    localparam int EW = 16 + LW;

    // request fields
    t_func       r_func;
    logic [15:0] r_hop;
    logic [7:0]  r_ttl;
    logic [15:0] r_cksum;
    logic [4:0]  r_port;
    logic [15:0] r_edge;
    logic [5:0]  r_bidx;
    logic [7:0]  r_bval;
    logic [7:0]  r_len;

    // stores
    logic [15:0]   r_pe_mem  [PD];
    logic [PD-1:0] r_pe_vld;
    logic [EW-1:0] r_ent_mem [NUM_HOPS];
    logic [7:0]    r_st_mem  [SD];
    logic [7:0]    r_stg_mem [MAX_REWRITE];

    logic [15:0]   r_pe_q;
    logic          r_pe_vq;
    logic [EW-1:0] r_ent_q;
    logic [7:0]    r_st_q;
    logic [7:0]    r_stg_q;

    logic [HW-1:0] r_clr;
    logic [SW-1:0] r_base;
    logic [LW-1:0] r_k;
    logic [LW-1:0] r_cnt;
    logic          r_wr_v;
    logic [SW-1:0] r_wr_addr;

    logic [1:0]    r_res_status;
    logic [15:0]   r_res_edge;
    logic [7:0]    r_res_ttl;
    logic [15:0]   r_res_ck;

    logic          r_o_valid;
    logic          r_o_hv;
    logic          r_o_last;
    logic [5:0]    r_o_idx;

    logic [HW-1:0] hop_idx;
    logic [PW-1:0] port_idx;
    logic          hop_ok;
    logic          port_ok;
    logic [15:0]   pe_edge;
    logic [15:0]   ent_edge;
    logic [LW-1:0] ent_len;
    t_status       cmt_status;
    t_status       n_status;
    logic          cmt_ok;
    logic [LW-1:0] n_cnt;
    logic          k_last;
    logic [SW-1:0] st_addr;
    logic [16:0]   ck_sum;
    logic [15:0]   ck_new;

    assign hop_idx  = r_hop[HW-1:0];
    assign port_idx = r_port[PW-1:0];
    assign hop_ok   = (32'(r_hop) < NUM_HOPS);
    assign port_ok  = (32'(r_port) < NUM_PORTS);
    assign pe_edge  = r_pe_vq ? r_pe_q : EDGE_NONE;
    assign ent_edge = r_ent_q[EW-1:LW];
    assign ent_len  = r_ent_q[LW-1:0];
    assign st_addr  = r_base + SW'(r_k);
    assign k_last   = (r_k == r_cnt - LW'(1));

    assign ck_sum = {1'b0, r_cksum} + {1'b0, CKSUM_ADJ};
    assign ck_new = ck_sum[15:0] + {15'd0, ck_sum[16]};

    always_comb begin
        if (!hop_ok) begin
            cmt_status = ST_BAD_HOP;
        end else if (32'(r_len) > MAX_REWRITE) begin
            cmt_status = ST_BAD_LEN;
        end else if (!port_ok || pe_edge == EDGE_NONE) begin
            cmt_status = ST_NO_EDGE;
        end else begin
            cmt_status = ST_OK;
        end
    end

    assign cmt_ok = (r_func == FN_COMMIT) && (cmt_status == ST_OK);

    always_comb begin
        n_status = ST_OK;
        n_cnt    = LW'(r_len);
        case (r_func)
            FN_PACKET: begin
                n_status = hop_ok ? ST_OK : ST_BAD_HOP;
                n_cnt    = ent_len;
            end
            FN_COMMIT: n_status = cmt_status;
            default:   n_status = ST_OK;
        endcase
    end

    assign o_stat.func     = r_func;
    assign o_stat.go_long  = (n_status == ST_OK) && (n_cnt != '0)
                             && (r_func == FN_PACKET || r_func == FN_COMMIT);
    assign o_stat.cnt_last = k_last;
    assign o_stat.clr_last = (32'(r_clr) == NUM_HOPS - 1);

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= t_func'(i_func);
            r_hop   <= i_hop_id;
            r_ttl   <= i_ttl;
            r_cksum <= i_cksum;
            r_port  <= i_port;
            r_edge  <= i_edge_req;
            r_bidx  <= i_byte_index;
            r_bval  <= i_byte_value;
            r_len   <= i_length;
        end
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + HW'(1);
        end
    end

    // port edge table, valid bits cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pe_vld <= '0;
        end else if (i_cmd.fetch && r_func == FN_SET_EDGE && port_ok) begin
            r_pe_vld[port_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch && r_func == FN_SET_EDGE && port_ok) begin
            r_pe_mem[port_idx] <= r_edge;
        end
        if (i_cmd.fetch) begin
            r_pe_q  <= r_pe_mem[port_idx];
            r_pe_vq <= r_pe_vld[port_idx];
        end
    end

    // next-hop entry table
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_ent_mem[r_clr] <= '0;
        end else if (i_cmd.decide && cmt_ok) begin
            r_ent_mem[hop_idx] <= {pe_edge, LW'(r_len)};
        end
        if (i_cmd.fetch) begin
            r_ent_q <= r_ent_mem[hop_idx];
            r_base  <= SW'(hop_idx) * SW'(MAX_REWRITE);
        end
    end

    // staging buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch && r_func == FN_STAGE && 32'(r_bidx) < MAX_REWRITE) begin
            r_stg_mem[r_bidx[KW-1:0]] <= r_bval;
        end
        if (i_cmd.copy) begin
            r_stg_q <= r_stg_mem[r_k[KW-1:0]];
        end
    end

    // rewrite byte store
    always_ff @(posedge i_clk) begin
        if (r_wr_v) begin
            r_st_mem[r_wr_addr] <= r_stg_q;
        end
        if (i_cmd.emit) begin
            r_st_q <= r_st_mem[st_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_v <= 1'b0;
        end else begin
            r_wr_v <= i_cmd.copy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy) begin
            r_wr_addr <= st_addr;
        end
    end

    // byte counter and per-request result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_k          <= '0;
            r_cnt        <= n_cnt;
            r_res_status <= n_status;
            r_res_edge   <= (r_func == FN_PACKET && hop_ok) ? ent_edge : EDGE_NONE;
            r_res_ttl    <= (r_func == FN_PACKET) ? r_ttl - 8'd1 : 8'd0;
            r_res_ck     <= (r_func == FN_PACKET) ? ck_new : 16'd0;
        end else if (i_cmd.emit || i_cmd.copy) begin
            r_k <= r_k + LW'(1);
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit || i_cmd.resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_hv   <= 1'b1;
            r_o_last <= k_last;
            r_o_idx  <= 6'(r_k);
        end else begin
            r_o_hv   <= 1'b0;
            r_o_last <= 1'b1;
            r_o_idx  <= 6'd0;
        end
    end

    assign o_strobe    = r_o_valid;
    assign o_status    = r_res_status;
    assign o_out_edge  = r_res_edge;
    assign o_new_ttl   = r_res_ttl;
    assign o_new_cksum = r_res_ck;
    assign o_hdr_byte  = r_o_hv ? r_st_q : 8'd0;
    assign o_hdr_index = r_o_idx;
    assign o_hdr_valid = r_o_hv;
    assign o_last      = r_o_last;

endmodule

[sv/ipv4_next_hop_rewrite_top.sv]
// ----------------------------------------------------------------------------
// ipv4_next_hop_rewrite_top
// IPv4 egress rewrite engine: next-hop lookup, TTL and checksum update.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low; busy
// stays high until the cycle that shows the last result of that request.
// Each result appears for one cycle with o_strobe high; the receiver cannot
// hold it off.
// Requests are handled one at a time by a lookup sequencer.
// Packet (func 0): a fetch and a decide step for the lookup, then one result
//   per cycle for each stored rewrite byte; a request with no bytes or a bad
//   next hop gives a single result.
// Set edge and stage byte: one result per request.
// Commit: copies the staged bytes one per cycle when it succeeds, then one result.
// The first result follows the fetch, decide and emit or response states
// and the result register; o_last marks the final one.
// Reset (synchronous, active low) clears the port edge valid bits and then
// sweeps the next-hop entry table to zero, one entry per cycle, with busy
// high. The rewrite byte store and staging buffer are not cleared.
// ----------------------------------------------------------------------------
module ipv4_next_hop_rewrite_top #(
    parameter int NUM_HOPS    = 64,
    parameter int MAX_REWRITE = 56,
    parameter int NUM_PORTS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_hop_id,
    input  logic [7:0]  i_ttl,
    input  logic [15:0] i_cksum,
    input  logic [4:0]  i_port,
    input  logic [15:0] i_edge_req,
    input  logic [5:0]  i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_length,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_edge,
    output logic [7:0]  o_new_ttl,
    output logic [15:0] o_new_cksum,
    output logic [7:0]  o_hdr_byte,
    output logic [5:0]  o_hdr_index,
    output logic        o_hdr_valid,
    output logic        o_last
);
    import nhrw_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    nhrw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    nhrw_dp #(
        .NUM_HOPS    (NUM_HOPS),
        .MAX_REWRITE (MAX_REWRITE),
        .NUM_PORTS   (NUM_PORTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_hop_id     (i_hop_id),
        .i_ttl        (i_ttl),
        .i_cksum      (i_cksum),
        .i_port       (i_port),
        .i_edge_req   (i_edge_req),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .i_length     (i_length),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_out_edge   (o_out_edge),
        .o_new_ttl    (o_new_ttl),
        .o_new_cksum  (o_new_cksum),
        .o_hdr_byte   (o_hdr_byte),
        .o_hdr_index  (o_hdr_index),
        .o_hdr_valid  (o_hdr_valid),
        .o_last       (o_last)
    );

endmodule

[sv/nhrw_checker.sv]
// ----------------------------------------------------------------------------
// nhrw_checker
// Port-level checks on request acceptance and result sequencing.
// ----------------------------------------------------------------------------
module nhrw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [15:0] o_out_edge,
    input logic [5:0]  o_hdr_index,
    input logic        o_hdr_valid,
    input logic        o_last
);
    import nhrw_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request accepted");

    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && o_hdr_valid)
        else $error("rewrite byte burst broken");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_hdr_valid && !o_last |=>
            o_hdr_index == $past(o_hdr_index) + 6'd1)
        else $error("header index did not advance by one");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_hdr_valid |-> o_last && o_hdr_index == 6'd0)
        else $error("single result not marked last");

    a_error_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_OK |-> o_out_edge == EDGE_NONE && !o_hdr_valid)
        else $error("failed request carries an edge or header byte");

endmodule

bind ipv4_next_hop_rewrite_top nhrw_checker u_nhrw_checker (.*);

[test/tb_ipv4_next_hop_rewrite_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_next_hop_rewrite_top
// Self-checking testbench for the IPv4 next-hop rewrite engine.
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge and taken when start is high and
// busy is low. A scoreboard keeps its own copy of the port edge table, the
// next-hop entries and the staging buffer. For each accepted request it works
// out the expected results: the TTL and checksum update, the rewrite bytes
// and the commit status. Strobed results are checked field by field against
// the oldest expectation. A short directed sequence covers field extremes,
// every operation and each error path. It is followed by randomised traffic,
// mostly well-formed stage/commit/packet sequences mixed with noise.
// ----------------------------------------------------------------------------
module tb_ipv4_next_hop_rewrite_top;
    import nhrw_pkg::*;

    localparam int NUM_HOPS     = 64;
    localparam int MAX_REWRITE  = 56;
    localparam int NUM_PORTS    = 32;
    localparam int RANDOM_ITEMS = 420;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        t_func       func;
        logic [15:0] hop_id;
        logic [7:0]  ttl;
        logic [15:0] cksum;
        logic [4:0]  port;
        logic [15:0] edge_req;
        logic [5:0]  byte_index;
        logic [7:0]  byte_value;
        logic [7:0]  length;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_edge;
        logic [7:0]  new_ttl;
        logic [15:0] new_cksum;
        logic [7:0]  hdr_byte;
        logic [5:0]  hdr_index;
        logic        hdr_valid;
        logic        last;
    } t_result;

    class rewrite_scoreboard;
        logic [15:0] port_edge [NUM_PORTS];
        logic [15:0] hop_edge [NUM_HOPS];
        logic [7:0]  hop_len [NUM_HOPS];
        logic [7:0]  hop_bytes [NUM_HOPS][MAX_REWRITE];
        logic [7:0]  staging [MAX_REWRITE];
        t_result     expected_results [$];
        int          mismatches;

        function new();
            foreach (port_edge[p]) port_edge[p] = EDGE_NONE;
            foreach (hop_edge[h]) begin
                hop_edge[h] = EDGE_NONE;
                hop_len[h]  = 8'd0;
            end
            mismatches = 0;
        endfunction

        function void note_request(t_request r);
            t_result     res;
            logic [16:0] sum;
            int          hop;
            int          n;
            res        = '0;
            res.status = ST_OK;
            res.last   = 1'b1;
            hop        = r.hop_id;
            case (r.func)
                FN_PACKET: begin
                    sum           = {1'b0, r.cksum} + {1'b0, CKSUM_ADJ};
                    res.new_ttl   = r.ttl - 8'd1;
                    res.new_cksum = sum[15:0] + {15'd0, sum[16]};
                    if (hop >= NUM_HOPS) begin
                        res.status   = ST_BAD_HOP;
                        res.out_edge = EDGE_NONE;
                        expected_results.push_back(res);
                    end else begin
                        res.out_edge = hop_edge[hop];
                        n = hop_len[hop];
                        if (n == 0) begin
                            expected_results.push_back(res);
                        end else begin
                            for (int k = 0; k < n; k++) begin
                                res.hdr_byte  = hop_bytes[hop][k];
                                res.hdr_index = 6'(k);
                                res.hdr_valid = 1'b1;
                                res.last      = (k == n - 1);
                                expected_results.push_back(res);
                            end
                        end
                    end
                end
                FN_SET_EDGE: begin
                    if (r.port < NUM_PORTS) port_edge[r.port] = r.edge_req;
                    expected_results.push_back(res);
                end
                FN_STAGE: begin
                    if (r.byte_index < MAX_REWRITE) staging[r.byte_index] = r.byte_value;
                    expected_results.push_back(res);
                end
                FN_COMMIT: begin
                    if (hop >= NUM_HOPS) begin
                        res.status = ST_BAD_HOP;
                    end else if (r.length > MAX_REWRITE) begin
                        res.status = ST_BAD_LEN;
                    end else if (r.port >= NUM_PORTS || port_edge[r.port] == EDGE_NONE) begin
                        res.status = ST_NO_EDGE;
                    end else begin
                        for (int k = 0; k < r.length; k++) hop_bytes[hop][k] = staging[k];
                        hop_len[hop]  = r.length;
                        hop_edge[hop] = port_edge[r.port];
                    end
                    expected_results.push_back(res);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: index %0d last %0b",
                       got.hdr_index, got.last);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("out_edge", want.out_edge, got.out_edge);
            compare_field("new_ttl", want.new_ttl, got.new_ttl);
            compare_field("new_cksum", want.new_cksum, got.new_cksum);
            compare_field("hdr_byte", want.hdr_byte, got.hdr_byte);
            compare_field("hdr_index", want.hdr_index, got.hdr_index);
            compare_field("hdr_valid", want.hdr_valid, got.hdr_valid);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [15:0] i_hop_id;
    logic [7:0]  i_ttl;
    logic [15:0] i_cksum;
    logic [4:0]  i_port;
    logic [15:0] i_edge_req;
    logic [5:0]  i_byte_index;
    logic [7:0]  i_byte_value;
    logic [7:0]  i_length;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [15:0] o_out_edge;
    logic [7:0]  o_new_ttl;
    logic [15:0] o_new_cksum;
    logic [7:0]  o_hdr_byte;
    logic [5:0]  o_hdr_index;
    logic        o_hdr_valid;
    logic        o_last;

    rewrite_scoreboard      board = new();
    logic [MAX_REWRITE-1:0] staged_mask;
    int                     issued;
    bit                     idle_on;
    int                     cycle_count = 0;

    ipv4_next_hop_rewrite_top #(
        .NUM_HOPS    (NUM_HOPS),
        .MAX_REWRITE (MAX_REWRITE),
        .NUM_PORTS   (NUM_PORTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_hop_id     (i_hop_id),
        .i_ttl        (i_ttl),
        .i_cksum      (i_cksum),
        .i_port       (i_port),
        .i_edge_req   (i_edge_req),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .i_length     (i_length),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_out_edge   (o_out_edge),
        .o_new_ttl    (o_new_ttl),
        .o_new_cksum  (o_new_cksum),
        .o_hdr_byte   (o_hdr_byte),
        .o_hdr_index  (o_hdr_index),
        .o_hdr_valid  (o_hdr_valid),
        .o_last       (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result seen;
        if (i_rst_n && o_strobe) begin
            seen.status    = t_status'(o_status);
            seen.out_edge  = o_out_edge;
            seen.new_ttl   = o_new_ttl;
            seen.new_cksum = o_new_cksum;
            seen.hdr_byte  = o_hdr_byte;
            seen.hdr_index = o_hdr_index;
            seen.hdr_valid = o_hdr_valid;
            seen.last      = o_last;
            board.check_result(seen);
        end
    end

    function automatic t_request make_request(t_func f);
        t_request r;
        r.func       = f;
        r.hop_id     = 16'($urandom);
        r.ttl        = 8'($urandom);
        r.cksum      = 16'($urandom);
        r.port       = 5'($urandom);
        r.edge_req   = 16'($urandom);
        r.byte_index = 6'($urandom);
        r.byte_value = 8'($urandom);
        r.length     = 8'($urandom);
        return r;
    endfunction

    // never commit staging positions that have not been written yet
    function automatic logic [7:0] safe_length(logic [7:0] want);
        int prefix;
        prefix = 0;
        while (prefix < MAX_REWRITE && staged_mask[prefix]) prefix++;
        if (want > MAX_REWRITE || want <= prefix) return want;
        return 8'(prefix);
    endfunction

    task automatic issue(t_request r);
        while (idle_on && $urandom_range(99) < 34) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        if (r.func == FN_STAGE && r.byte_index < MAX_REWRITE) staged_mask[r.byte_index] = 1'b1;
        if (r.func == FN_COMMIT) r.length = safe_length(r.length);
        i_func       = r.func;
        i_hop_id     = r.hop_id;
        i_ttl        = r.ttl;
        i_cksum      = r.cksum;
        i_port       = r.port;
        i_edge_req   = r.edge_req;
        i_byte_index = r.byte_index;
        i_byte_value = r.byte_value;
        i_length     = r.length;
        start        = 1'b1;
        do @(posedge i_clk); while (busy);
        board.note_request(r);
        issued++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic send_packet(logic [15:0] hop, logic [7:0] ttl, logic [15:0] ck);
        t_request r;
        r          = make_request(FN_PACKET);
        r.hop_id   = hop;
        r.ttl      = ttl;
        r.cksum    = ck;
        issue(r);
    endtask

    task automatic set_edge(logic [4:0] p, logic [15:0] e);
        t_request r;
        r          = make_request(FN_SET_EDGE);
        r.port     = p;
        r.edge_req = e;
        issue(r);
    endtask

    task automatic stage(logic [5:0] idx, logic [7:0] val);
        t_request r;
        r            = make_request(FN_STAGE);
        r.byte_index = idx;
        r.byte_value = val;
        issue(r);
    endtask

    task automatic commit(logic [15:0] hop, logic [7:0] len, logic [4:0] p);
        t_request r;
        r          = make_request(FN_COMMIT);
        r.hop_id   = hop;
        r.length   = len;
        r.port     = p;
        issue(r);
    endtask

    initial begin
        int   base;
        int   sel;
        int   hop;
        int   len;
        int   p;
        bit   paused;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = FN_PACKET;
        i_hop_id     = '0;
        i_ttl        = '0;
        i_cksum      = '0;
        i_port       = '0;
        i_edge_req   = '0;
        i_byte_index = '0;
        i_byte_value = '0;
        i_length     = '0;
        staged_mask  = '0;
        issued       = 0;
        idle_on      = 1'b1;
        paused       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: wraps, carries, error priority, ignored indices
        send_packet(16'd0, 8'h00, 16'hffff);
        send_packet(16'hffff, 8'hff, 16'hff00);
        send_packet(16'(NUM_HOPS), 8'h01, 16'h0000);
        commit(16'd3, 8'd0, 5'd0);
        set_edge(5'd0, 16'hffff);
        set_edge(5'd31, 16'h0001);
        commit(16'd5, 8'd0, 5'd0);
        send_packet(16'd5, 8'h80, 16'h1234);
        commit(16'hffff, 8'd255, 5'd7);
        commit(16'(NUM_HOPS), 8'd0, 5'd0);
        commit(16'd10, 8'(MAX_REWRITE + 1), 5'd0);
        commit(16'd10, 8'd255, 5'd7);
        commit(16'd10, 8'd0, 5'd7);
        stage(6'd0, 8'h00);
        stage(6'd1, 8'hff);
        stage(6'd63, 8'h5a);
        stage(6'(MAX_REWRITE), 8'ha5);
        commit(16'(NUM_HOPS - 1), 8'd2, 5'd31);
        send_packet(16'(NUM_HOPS - 1), 8'hff, 16'hfeff);
        set_edge(5'd31, EDGE_NONE);
        commit(16'd1, 8'd0, 5'd31);
        send_packet(16'(NUM_HOPS - 1), 8'h40, 16'h00ff);

        while (board.expected_results.size() != 0) @(negedge i_clk);

        for (int k = 0; k < MAX_REWRITE; k++) stage(6'(k), 8'($urandom));

        base = issued;
        while (issued - base < RANDOM_ITEMS) begin
            idle_on = !((issued - base) >= 150 && (issued - base) < 270);
            if (!paused && (issued - base) >= 350) begin
                paused = 1'b1;
                while (board.expected_results.size() != 0) @(negedge i_clk);
            end
            sel = $urandom_range(99);
            if (sel < 45) begin
                hop = ($urandom_range(9) == 0) ? $urandom_range(65535, NUM_HOPS)
                                               : $urandom_range(NUM_HOPS - 1);
                send_packet(16'(hop), 8'($urandom), 16'($urandom));
            end else if (sel < 65) begin
                // well-formed rewrite: edge, header bytes, commit, then use it
                sel = $urandom_range(19);
                len = (sel == 0) ? MAX_REWRITE : (sel == 1) ? 0 : $urandom_range(16, 1);
                hop = $urandom_range(NUM_HOPS - 1);
                p   = $urandom_range(NUM_PORTS - 1);
                if ($urandom_range(9) != 0) set_edge(5'(p), 16'($urandom_range(65535, 1)));
                for (int k = 0; k < len; k++) stage(6'(k), 8'($urandom));
                commit(16'(hop), 8'(len), 5'(p));
                send_packet(16'(hop), 8'($urandom), 16'($urandom));
            end else if (sel < 75) begin
                set_edge(5'($urandom), ($urandom_range(4) == 0) ? EDGE_NONE : 16'($urandom));
            end else if (sel < 85) begin
                stage(6'($urandom), 8'($urandom));
            end else begin
                hop = ($urandom_range(9) == 0) ? $urandom_range(65535, NUM_HOPS)
                                               : $urandom_range(NUM_HOPS - 1);
                len = $urandom_range(1) ? $urandom_range(255) : $urandom_range(MAX_REWRITE);
                commit(16'(hop), 8'(len), 5'($urandom));
            end
        end

        start = 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
